>>> rtl/sxc_pkg.sv
// ----------------------------------------------------------------------------
// sxc_pkg - shared definitions for the subarray XOR count block
// Widths, count store geometry, sequencer codes and the trie index function.
// ----------------------------------------------------------------------------
package sxc_pkg;

  // value and counter geometry
  localparam int VALUE_BITS = 20;
  localparam int K_W        = 20;
  localparam int CNT_W      = 21;
  localparam int TOTAL_W    = 40;
  localparam int ACC_W      = 26;   // holds VALUE_BITS full counters summed
  localparam int LVL_W      = $clog2(VALUE_BITS);
  localparam int ADDR_W     = VALUE_BITS + 1;
  localparam int STORE_SIZE = (2 ** ADDR_W) - 2;

  // stream widths, padded to whole bytes
  localparam int S_TDATA_W  = ((VALUE_BITS + 7) / 8) * 8;
  localparam int M_TDATA_W  = ((TOTAL_W + 7) / 8) * 8;

  localparam logic [CNT_W-1:0]   COUNT_MAX = {CNT_W{1'b1}};
  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};
  localparam logic [LVL_W-1:0]   LVL_LAST  = LVL_W'(VALUE_BITS - 1);

  // sequencer states
  typedef enum logic [2:0] {
    S_IDLE,
    S_INS,
    S_QRY,
    S_DRAIN,
    S_TOT
  } state_e;

  // kind of read in flight towards the shared adder
  typedef enum logic [1:0] {
    TAG_NONE,
    TAG_INS,
    TAG_QRY
  } tag_e;

  // count store access request
  typedef struct packed {
    logic              rd_en;
    logic [ADDR_W-1:0] rd_addr;
    logic              wr_en;
    logic [ADDR_W-1:0] wr_addr;
    logic [CNT_W-1:0]  wr_data;
  } store_req_t;

  // Store entry for the top (lvl+1) bits of v; level d starts at 2^d - 2
  function automatic logic [ADDR_W-1:0] store_index(input logic [LVL_W-1:0]      lvl,
                                                    input logic [VALUE_BITS-1:0] v);
    logic [ADDR_W-1:0]     base;
    logic [VALUE_BITS-1:0] top;
    base = (ADDR_W'(2) << lvl) - ADDR_W'(2);
    top  = v >> (LVL_LAST - lvl);
    return base + ADDR_W'(top);
  endfunction

endpackage

>>> rtl/subarray_xor_below_threshold_count_top.sv
// ----------------------------------------------------------------------------
// subarray_xor_below_threshold_count_top - running count of subarrays whose
// XOR is below a threshold, using a counted binary trie in one memory.
// ----------------------------------------------------------------------------
//  channel   dir  fields (low bit first)                    handshake
//  s_axis    in   tdata: element_value[19:0]; tlast: last   tvalid/tready
//  m_axis    out  tdata: running_count[39:0]; tlast: final  tvalid/tready
//  cfg       in   cfg_data_i: threshold_k[19:0]             cfg_valid_i/cfg_ready_o
//
//  An item passes through accept, 20 insert reads with overlapped
//  read-modify-write, 20 query reads, one drain and one total update.
//  Separate read and write ports on the count memory and the shared adder set them.
//  After reset all 2097150 memory entries are swept to zero; no item is
//  taken meanwhile, configuration writes are.
//  A stalled result waits in the output register; the next item is taken
//  and held back only at its final total update.
// ----------------------------------------------------------------------------
module subarray_xor_below_threshold_count_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input items
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [sxc_pkg::S_TDATA_W-1:0] s_axis_tdata,   // [19:0] element_value
  input  logic                          s_axis_tlast,   // last_item
  // result items
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [sxc_pkg::M_TDATA_W-1:0] m_axis_tdata,   // [39:0] running_count
  output logic                          m_axis_tlast,   // is_final
  // threshold register write
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [sxc_pkg::K_W-1:0]       cfg_data_i      // threshold_k
);
  import sxc_pkg::*;

  state_e                state_q, state_d;
  logic [LVL_W-1:0]      lvl_q, lvl_d;
  logic [VALUE_BITS-1:0] prefix_q, prefix_d;
  logic [VALUE_BITS-1:0] elem_q;
  logic                  last_q;
  logic [K_W-1:0]        k_q;
  logic [ACC_W-1:0]      acc_q, acc_d;
  logic [TOTAL_W-1:0]    total_q, total_d;

  // read pipeline tag
  tag_e                  tag_q, tag_d;
  logic [ADDR_W-1:0]     paddr_q, paddr_d;
  logic                  pkbit_q, pkbit_d;

  // output register
  logic                  out_valid_q, out_valid_d;
  logic [TOTAL_W-1:0]    out_count_q;
  logic                  out_final_q;
  logic                  out_load;

  store_req_t            store_req;
  logic [CNT_W-1:0]      rd_data;
  logic                  store_ready;

  logic                  in_acc;
  logic [LVL_W-1:0]      bpos;
  logic [VALUE_BITS-1:0] target;
  logic [ACC_W-1:0]      opnd;
  logic [ACC_W-1:0]      sum;
  logic [TOTAL_W:0]      tot_sum;

  sxc_count_store u_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .req_i     (store_req),
    .rd_data_o (rd_data),
    .ready_o   (store_ready)
  );

  assign s_axis_tready = (state_q == S_IDLE) && store_ready;
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  // query target: agrees with prefix^k above bit b, with prefix at bit b
  assign bpos   = LVL_LAST - lvl_q;
  assign target = prefix_q ^ k_q ^ (VALUE_BITS'(1) << bpos);

  // shared adder: counter increment on insert, accumulate on query
  assign opnd = (tag_q == TAG_INS) ? ACC_W'(1) : acc_q;
  assign sum  = ACC_W'(rd_data) + opnd;

  assign tot_sum = {1'b0, total_q} + (TOTAL_W + 1)'(acc_q);

  // sequencer: next state, store requests and datapath updates
  always_comb begin
    state_d     = state_q;
    lvl_d       = lvl_q;
    prefix_d    = prefix_q;
    acc_d       = acc_q;
    total_d     = total_q;
    tag_d       = TAG_NONE;
    paddr_d     = paddr_q;
    pkbit_d     = 1'b0;
    out_load    = 1'b0;
    store_req   = '0;

    // write back or accumulate the data read last cycle
    unique case (tag_q)
      TAG_INS: begin
        store_req.wr_en   = (rd_data != COUNT_MAX);
        store_req.wr_addr = paddr_q;
        store_req.wr_data = sum[CNT_W-1:0];
      end
      TAG_QRY: begin
        if (pkbit_q) begin
          acc_d = sum;
        end
      end
      default: ;
    endcase

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          acc_d   = '0;
          lvl_d   = '0;
          state_d = S_INS;
        end
      end
      S_INS: begin
        store_req.rd_en   = 1'b1;
        store_req.rd_addr = store_index(lvl_q, prefix_q);
        tag_d             = TAG_INS;
        paddr_d           = store_req.rd_addr;
        if (lvl_q == LVL_LAST) begin
          lvl_d    = '0;
          prefix_d = prefix_q ^ elem_q;
          state_d  = S_QRY;
        end else begin
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      S_QRY: begin
        store_req.rd_en   = 1'b1;
        store_req.rd_addr = store_index(lvl_q, target);
        tag_d             = TAG_QRY;
        paddr_d           = store_req.rd_addr;
        pkbit_d           = k_q[bpos];
        if (lvl_q == LVL_LAST) begin
          lvl_d   = '0;
          state_d = S_DRAIN;
        end else begin
          lvl_d = lvl_q + LVL_W'(1);
        end
      end
      S_DRAIN: begin
        state_d = S_TOT;
      end
      S_TOT: begin
        if (!out_valid_q || m_axis_tready) begin
          total_d  = tot_sum[TOTAL_W] ? TOTAL_MAX : tot_sum[TOTAL_W-1:0];
          out_load = 1'b1;
          state_d  = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // output valid follows load and take
  always_comb begin
    out_valid_d = out_valid_q;
    if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      lvl_q       <= '0;
      prefix_q    <= '0;
      acc_q       <= '0;
      total_q     <= '0;
      tag_q       <= TAG_NONE;
      pkbit_q     <= 1'b0;
      out_valid_q <= 1'b0;
      k_q         <= '0;
    end else begin
      state_q     <= state_d;
      lvl_q       <= lvl_d;
      prefix_q    <= prefix_d;
      acc_q       <= acc_d;
      total_q     <= total_d;
      tag_q       <= tag_d;
      pkbit_q     <= pkbit_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i) begin
        k_q <= cfg_data_i;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    paddr_q <= paddr_d;
    if (in_acc) begin
      elem_q <= s_axis_tdata[VALUE_BITS-1:0];
      last_q <= s_axis_tlast;
    end
    if (out_load) begin
      out_count_q <= total_d;
      out_final_q <= last_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = M_TDATA_W'(out_count_q);
  assign m_axis_tlast  = out_final_q;

`ifndef SYNTHESIS
  // no item enters before the store sweep is done
  a_ready_after_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready |-> store_ready)
    else $error("item taken while count store is clearing");

  // an accepted item starts its insert walk with an empty accumulator
  a_accept_starts_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> state_q == S_INS && acc_q == '0 && lvl_q == '0)
    else $error("insert walk did not start cleanly");

  // running total never decreases
  a_total_monotonic: assert property (@(posedge clk_i) disable iff (!rst_ni)
    1'b1 |=> total_q >= $past(total_q))
    else $error("running total decreased");

  // counters are written back only for insert reads
  a_write_on_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    store_req.wr_en |-> tag_q == TAG_INS)
    else $error("count store written outside insert walk");
`endif

endmodule

>>> rtl/sxc_count_store.sv
// ----------------------------------------------------------------------------
// sxc_count_store - prefix counter memory of the binary trie
// One write and one registered read per cycle; swept to zero after reset.
// ----------------------------------------------------------------------------
module sxc_count_store (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  sxc_pkg::store_req_t       req_i,
  output logic [sxc_pkg::CNT_W-1:0] rd_data_o,
  output logic                      ready_o
);
  import sxc_pkg::*;

  logic [CNT_W-1:0]  count_mem [STORE_SIZE];
  logic [CNT_W-1:0]  rd_data_q;
  logic [ADDR_W-1:0] clr_addr_q, clr_addr_d;
  logic              clr_busy_q, clr_busy_d;
  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [CNT_W-1:0]  wdata;

  // clearing sweep, one entry a cycle
  always_comb begin
    clr_addr_d = clr_addr_q;
    clr_busy_d = clr_busy_q;
    if (clr_busy_q) begin
      clr_addr_d = clr_addr_q + ADDR_W'(1);
      if (clr_addr_q == ADDR_W'(STORE_SIZE - 1)) begin
        clr_busy_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_addr_q <= '0;
      clr_busy_q <= 1'b1;
    end else begin
      clr_addr_q <= clr_addr_d;
      clr_busy_q <= clr_busy_d;
    end
  end

  // write port: the sweep owns it until done
  assign we    = clr_busy_q | req_i.wr_en;
  assign waddr = clr_busy_q ? clr_addr_q : req_i.wr_addr;
  assign wdata = clr_busy_q ? '0 : req_i.wr_data;

  always_ff @(posedge clk_i) begin
    if (we) begin
      count_mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= count_mem[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;
  assign ready_o   = ~clr_busy_q;

`ifndef SYNTHESIS
  // user traffic only once the sweep has finished
  a_no_req_while_clearing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !req_i.rd_en && !req_i.wr_en)
    else $error("count store accessed during clearing sweep");

  // sweep stays inside the store
  a_clr_addr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> clr_addr_q < ADDR_W'(STORE_SIZE))
    else $error("clearing sweep address out of range");

  // sweep ends exactly after the last entry
  a_clr_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(clr_busy_q) |-> clr_addr_q == ADDR_W'(STORE_SIZE))
    else $error("clearing sweep ended early");
`endif

endmodule

>>> bench/tb_subarray_xor_below_threshold_count_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_subarray_xor_below_threshold_count_top - self-checking bench
// Streams array elements into the block under several thresholds and checks
// every running count against a counted-trie predictor held in a small
// scoreboard. Both stream sides idle at random; results are checked in order.
// ----------------------------------------------------------------------------
module tb_subarray_xor_below_threshold_count_top;
  import sxc_pkg::*;

  localparam int PHASE_ITEMS = 250;

  // one expected result item
  typedef struct {
    logic [TOTAL_W-1:0] count;
    logic               is_last;
  } count_result_t;

  // running-count predictor and store of pending results
  class count_scoreboard;
    logic [K_W-1:0]         threshold;
    logic [VALUE_BITS-1:0]  prefix;
    logic [TOTAL_W-1:0]     total;
    logic [CNT_W-1:0]       level_counts [int unsigned];
    count_result_t          pending [$];
    int unsigned            errors;

    function new();
      threshold = '0;
      prefix    = '0;
      total     = '0;
      errors    = 0;
    endfunction

    // entry for the top lvl bits of v, lvl from 1 to VALUE_BITS
    function int unsigned entry_of(int unsigned lvl, logic [VALUE_BITS-1:0] v);
      return ((32'd1 << lvl) - 32'd2) + (32'(v) >> (VALUE_BITS - lvl));
    endfunction

    function logic [CNT_W-1:0] count_at(int unsigned idx);
      return level_counts.exists(idx) ? level_counts[idx] : '0;
    endfunction

    // accepted element: insert old prefix, fold in, count matching prefixes
    function void note_element(logic [VALUE_BITS-1:0] elem, logic is_last);
      logic [VALUE_BITS-1:0] target;
      longint unsigned       add;
      int unsigned           idx;
      count_result_t         res;
      for (int unsigned lvl = 1; lvl <= VALUE_BITS; lvl++) begin
        idx = entry_of(lvl, prefix);
        if (count_at(idx) != COUNT_MAX) level_counts[idx] = count_at(idx) + 1'b1;
      end
      prefix = prefix ^ elem;
      add = 0;
      for (int unsigned lvl = 1; lvl <= VALUE_BITS; lvl++) begin
        if (threshold[VALUE_BITS - lvl]) begin
          target = prefix ^ threshold ^ (VALUE_BITS'(1) << (VALUE_BITS - lvl));
          add += count_at(entry_of(lvl, target));
        end
      end
      if (add > longint'(TOTAL_MAX - total)) total = TOTAL_MAX;
      else total = total + TOTAL_W'(add);
      res.count   = total;
      res.is_last = is_last;
      pending.push_back(res);
    endfunction

    // accepted result against the oldest expectation
    function void check_result(logic [TOTAL_W-1:0] count, logic is_last);
      count_result_t want;
      if (pending.size() == 0) begin
        $error("unexpected result: running_count=%0d is_final=%0b", count, is_last);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (count !== want.count) begin
        $error("running_count: expected %0d, got %0d", want.count, count);
        errors++;
      end
      if (is_last !== want.is_last) begin
        $error("is_final: expected %0b, got %0b", want.is_last, is_last);
        errors++;
      end
    endfunction
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [S_TDATA_W-1:0] s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_axis_tdata;
  logic                 m_axis_tlast;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [K_W-1:0]       cfg_data_i    = '0;

  bit src_quiet = 1'b0;
  bit snk_quiet = 1'b0;

  count_scoreboard sb = new();

  subarray_xor_below_threshold_count_top dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // threshold write, only while nothing is in flight
  task automatic write_threshold(input logic [K_W-1:0] k);
    cfg_data_i  <= k;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.threshold = k;
    cfg_valid_i <= 1'b0;
  endtask

  // one element item with a random gap ahead of it
  task automatic send_element(input logic [VALUE_BITS-1:0] elem, input logic is_last);
    int unsigned gap;
    if ($urandom_range(0, 19) == 0) src_quiet = ~src_quiet;
    gap = src_quiet ? 0 : $urandom_range(0, 14);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= S_TDATA_W'(elem);
    s_axis_tlast  <= is_last;
    do @(posedge clk_i); while (!s_axis_tready);
    sb.note_element(elem, is_last);
  endtask

  // mix of full-range, clustered, one-hot, prefix-cancelling and all-ones or all-zero elements
  function automatic logic [VALUE_BITS-1:0] draw_element();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return VALUE_BITS'($urandom);
      4, 5, 6:    return VALUE_BITS'($urandom_range(0, 15));
      7:          return VALUE_BITS'(1) << $urandom_range(0, VALUE_BITS - 1);
      8:          return sb.prefix;   // brings the prefix back to zero
      default:    return $urandom_range(0, 1) ? '1 : '0;
    endcase
  endfunction

  task automatic run_phase(input logic [K_W-1:0] k);
    while (sb.pending.size() != 0) @(posedge clk_i);
    write_threshold(k);
    for (int i = 0; i < PHASE_ITEMS; i++)
      send_element(draw_element(), $urandom_range(0, 31) == 0);
    s_axis_tvalid <= 1'b0;
  endtask

  // result side: random stalls, with quiet stretches
  initial begin
    int unsigned stall;
    @(posedge rst_ni);
    forever begin
      if ($urandom_range(0, 19) == 0) snk_quiet = ~snk_quiet;
      stall = snk_quiet ? 0 : $urandom_range(0, 14);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
    end
  end

  // result monitor
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_result(m_axis_tdata[TOTAL_W-1:0], m_axis_tlast);
  end

  // stimulus
  initial begin
    logic [VALUE_BITS-1:0] directed [15];
    directed = '{20'h00000, 20'h00000, 20'hFFFFF, 20'hFFFFF, 20'h80000,
                 20'h00001, 20'hAAAAA, 20'h55555, 20'hFFFFF, 20'h00000,
                 20'h12345, 20'h12345, 20'h7FFFF, 20'h00010, 20'h80000};
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: field extremes, and elements carrying on after a last item
    write_threshold('1);
    foreach (directed[i]) send_element(directed[i], i == 8 || i == 14);
    s_axis_tvalid <= 1'b0;

    run_phase('0);
    run_phase(K_W'(1));
    run_phase(K_W'($urandom));
    run_phase(K_W'(20'h80000));
    run_phase(K_W'($urandom_range(0, 255)));
    run_phase(K_W'(20'h7FFFF));
    run_phase('1);

    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // overall limit, covering the store clear after reset
  initial begin
    #40ms;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
